/* rtl/apfc_pkg.sv */
package apfc_pkg;

    localparam int BYTE_W  = 7;
    localparam int COUNT_W = 7;
    localparam int CLASS_W = 3;
    localparam int LEN_W   = 5;
    localparam int DEC_W   = 13;

    localparam int LONG_FRAME_BYTES_DEF  = 19;
    localparam int SHORT_FRAME_BYTES_DEF = 6;
    localparam int BUFFER_LIMIT_DEF      = 64;

    localparam logic [BYTE_W-1:0] HEAD_BYTE  = 7'h01;
    localparam logic [BYTE_W-1:0] SHORT_MARK = 7'h4C;

    localparam logic [CLASS_W-1:0] CLASS_NONE   = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_ALARM  = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_FAULT  = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_RESET  = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_SHIELD = 3'd4;
    localparam logic [CLASS_W-1:0] CLASS_OUTING = 3'd5;

    typedef enum logic [3:0] {
        PHASE_HUNT  = 4'b0001,
        PHASE_HEAD  = 4'b0010,
        PHASE_LONG  = 4'b0100,
        PHASE_SHORT = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b4;
        logic [BYTE_W-1:0] b8;
        logic [BYTE_W-1:0] b9;
        logic [BYTE_W-1:0] b10;
        logic [BYTE_W-1:0] b11;
        logic [BYTE_W-1:0] b13;
        logic [BYTE_W-1:0] b14;
        logic [BYTE_W-1:0] b15;
        logic [BYTE_W-1:0] b16;
    } frame_fields_t;

endpackage

/* rtl/apfc_framer.sv */
module apfc_framer
    import apfc_pkg::*;
#(
    parameter int LONG_FRAME_BYTES  = LONG_FRAME_BYTES_DEF,
    parameter int SHORT_FRAME_BYTES = SHORT_FRAME_BYTES_DEF,
    parameter int BUFFER_LIMIT      = BUFFER_LIMIT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [BYTE_W-1:0]   rx_bits,
    output logic                emit,
    output logic [LEN_W-1:0]    length,
    output frame_fields_t       fields
);

    localparam int IDX_W = $clog2(LONG_FRAME_BYTES);
    localparam logic [COUNT_W-1:0] LONG_CNT  = COUNT_W'(LONG_FRAME_BYTES);
    localparam logic [COUNT_W-1:0] SHORT_CNT = COUNT_W'(SHORT_FRAME_BYTES);
    localparam logic [COUNT_W-1:0] LIMIT_CNT = COUNT_W'(BUFFER_LIMIT - 2);

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0]   store_reg [LONG_FRAME_BYTES];
    logic [BYTE_W-1:0]   view      [LONG_FRAME_BYTES];
    logic [COUNT_W-1:0]  count_inc;
    logic [COUNT_W-1:0]  target;

    assign count_inc = count_reg + COUNT_W'(1);
    assign target    = (phase_reg == PHASE_LONG) ? LONG_CNT : SHORT_CNT;
    assign length    = count_inc[LEN_W-1:0];

    // frame as it stands with this beat merged, bytes past the length read zero
    always_comb
    begin
        for (int i = 0; i < LONG_FRAME_BYTES; i++)
        begin
            if (COUNT_W'(i) == count_reg)
                view[i] = rx_bits;
            else if (COUNT_W'(i) < count_inc)
                view[i] = store_reg[i];
            else
                view[i] = '0;
        end
    end

    assign fields.b1  = view[1];
    assign fields.b2  = view[2];
    assign fields.b4  = view[4];
    assign fields.b8  = view[8];
    assign fields.b9  = view[9];
    assign fields.b10 = view[10];
    assign fields.b11 = view[11];
    assign fields.b13 = view[13];
    assign fields.b14 = view[14];
    assign fields.b15 = view[15];
    assign fields.b16 = view[16];

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        emit       = 1'b0;
        case (phase_reg)
            PHASE_HUNT:
            begin
                if (rx_bits == HEAD_BYTE)
                begin
                    phase_next = PHASE_HEAD;
                    count_next = count_inc;
                end
                else
                begin
                    count_next = '0;
                end
            end
            PHASE_HEAD:
            begin
                phase_next = (rx_bits == SHORT_MARK) ? PHASE_SHORT : PHASE_LONG;
                count_next = count_inc;
            end
            PHASE_LONG, PHASE_SHORT:
            begin
                if (count_inc >= target)
                begin
                    emit       = 1'b1;
                    phase_next = PHASE_HUNT;
                    count_next = '0;
                end
                else if (count_inc >= LIMIT_CNT)
                begin
                    phase_next = PHASE_HUNT;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            default:
            begin
                phase_next = PHASE_HUNT;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_HUNT;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (count_reg < LONG_CNT))
            store_reg[count_reg[IDX_W-1:0]] <= rx_bits;
    end

endmodule

/* rtl/apfc_classifier.sv */
module apfc_classifier
    import apfc_pkg::*;
(
    input  frame_fields_t        fields,
    output logic [CLASS_W-1:0]   msg_class,
    output logic [DEC_W-1:0]     loop_address,
    output logic [DEC_W-1:0]     device_number
);

    function automatic logic [7:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [7:0] s;
        s = {1'b0, c} - 8'h30;
        if (s > 8'd9)
            s = s - 8'd7;
        return s;
    endfunction

    logic [7:0] d8, d9, d10, d11;
    logic       is_reset, is_outing, is_shield, is_fault, is_alarm;
    logic       tail_4f, tail_w01;

    assign d8  = hex_digit(fields.b8);
    assign d9  = hex_digit(fields.b9);
    assign d10 = hex_digit(fields.b10);
    assign d11 = hex_digit(fields.b11);

    assign loop_address  = DEC_W'({d8, 4'b0000}) + DEC_W'(d9);
    assign device_number = DEC_W'({d10, 4'b0000}) + DEC_W'(d11);

    assign tail_4f  = (fields.b15 == 7'h34) && (fields.b16 == 7'h46);
    assign tail_w01 = ((fields.b15 == 7'h30) &&
                       ((fields.b16 == 7'h30) || (fields.b16 == 7'h31) ||
                        (fields.b16 == 7'h32)))
                      || ((fields.b15 == 7'h38) && (fields.b16 == 7'h35))
                      || tail_4f;

    assign is_reset  = (fields.b13 == 7'h30) && (fields.b14 == 7'h36) &&
                       (fields.b15 == 7'h38) && (fields.b16 == 7'h35);
    assign is_outing = (fields.b1 == 7'h4C) && (fields.b2 == 7'h30);
    assign is_shield = (fields.b15 == 7'h35) && (fields.b16 == 7'h36);
    assign is_fault  = (fields.b15 == 7'h34) && (fields.b16 == 7'h36);
    assign is_alarm  = ((fields.b4 == 7'h57) && (fields.b13 == 7'h30) &&
                        (fields.b14 == 7'h31) && tail_w01)
                     || ((fields.b4 == 7'h57) &&
                         ((fields.b13 == 7'h36) || (fields.b13 == 7'h37)) &&
                         (fields.b14 == 7'h32) && tail_4f)
                     || ((fields.b4 == 7'h50) && (fields.b13 == 7'h36) &&
                         (fields.b14 == 7'h32) && tail_4f);

    // priority order
    always_comb
    begin
        if (is_reset)
            msg_class = CLASS_RESET;
        else if (is_outing)
            msg_class = CLASS_OUTING;
        else if (is_shield)
            msg_class = CLASS_SHIELD;
        else if (is_alarm)
            msg_class = CLASS_ALARM;
        else if (is_fault)
            msg_class = CLASS_FAULT;
        else
            msg_class = CLASS_NONE;
    end

endmodule

/* rtl/alarm_panel_frame_classifier_unit.sv */
// path: a closing beat is held in the input register, its result then in the output register
// throughput: one byte per cycle unless stalled, set by the single input-to-result pass
// while a result waits in the output register, the input register takes a new beat only if empty or the result is taken
// reset: asynchronous, active low; framer hunts for a head byte, no beat or result held
module alarm_panel_frame_classifier_unit
    import apfc_pkg::*;
#(
    parameter int LONG_FRAME_BYTES  = LONG_FRAME_BYTES_DEF,
    parameter int SHORT_FRAME_BYTES = SHORT_FRAME_BYTES_DEF,
    parameter int BUFFER_LIMIT      = BUFFER_LIMIT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CLASS_W-1:0]  msg_class,
    output logic [LEN_W-1:0]    frame_length,
    output logic [DEC_W-1:0]    loop_address,
    output logic [DEC_W-1:0]    device_number
);

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_bits_reg;
    logic                advance;
    logic                emit;
    logic [LEN_W-1:0]    length;
    frame_fields_t       fields;
    logic [CLASS_W-1:0]  class_next;
    logic [DEC_W-1:0]    loop_next;
    logic [DEC_W-1:0]    device_next;
    logic                out_valid_reg;
    logic [CLASS_W-1:0]  class_reg;
    logic [LEN_W-1:0]    length_reg;
    logic [DEC_W-1:0]    loop_reg;
    logic [DEC_W-1:0]    device_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    apfc_framer #(
        .LONG_FRAME_BYTES  (LONG_FRAME_BYTES),
        .SHORT_FRAME_BYTES (SHORT_FRAME_BYTES),
        .BUFFER_LIMIT      (BUFFER_LIMIT)
    ) u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_bits (in_bits_reg),
        .emit    (emit),
        .length  (length),
        .fields  (fields)
    );

    apfc_classifier u_classifier (
        .fields        (fields),
        .msg_class     (class_next),
        .loop_address  (loop_next),
        .device_number (device_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_bits_reg <= rx_byte[BYTE_W-1:0];
        if (advance && emit)
        begin
            class_reg  <= class_next;
            length_reg <= length;
            loop_reg   <= loop_next;
            device_reg <= device_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign msg_class     = class_reg;
    assign frame_length  = length_reg;
    assign loop_address  = loop_reg;
    assign device_number = device_reg;

endmodule
